// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define OLIST_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is active
`define OLIST_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/olist_pkg.sv =====
// types, sizes and codes for the ordered list engine
// no dependencies
`default_nettype none

package olist_pkg;

	// store size and derived widths
	localparam int DEPTH   = 128;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int POS_W   = 8;
	localparam int LEN_W   = 8;
	localparam int DATA_W  = 32;
	localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	// search scan: match bits are examined one group per cycle
	localparam int SCAN_LG = 3;
	localparam int SCAN_W  = 1 << SCAN_LG;
	localparam int NGRP    = (DEPTH + SCAN_W - 1) / SCAN_W;
	localparam int GRP_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int PAD_W   = NGRP * SCAN_W;

	typedef enum logic [2:0] {
		OP_APPEND  = 3'd0,
		OP_INSERT  = 3'd1,
		OP_DELETE  = 3'd2,
		OP_SEARCH  = 3'd3,
		OP_REPLACE = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic                     ins;
		logic                     del;
		logic                     rep;
		logic [IDX_W-1:0]         idx;
		logic [CNT_W-1:0]         cnt;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] new_value;
	} cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/olist_if.sv =====
// request and response channel interfaces of the ordered list engine
// depends on olist_pkg
`default_nettype none

interface olist_req_if import olist_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [2:0]               opcode;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;
	logic signed [DATA_W-1:0] new_value;

	modport source (output valid, opcode, position, value, new_value, input ready);
	modport sink (input valid, opcode, position, value, new_value, output ready);
endinterface

interface olist_rsp_if import olist_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [LEN_W-1:0] found_position;
	logic [LEN_W-1:0] list_length;

	modport source (output valid, status, found_position, list_length, input ready);
	modport sink (input valid, status, found_position, list_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/olist_cell.sv =====
// one list cell: holds one entry, shifts with its neighbors, matches a value
// depends on olist_pkg
`default_nettype none

module olist_cell import olist_pkg::*; (
	input  wire                      clk,
	input  wire [IDX_W-1:0]          index,
	input  cell_cmd_t                cmd,
	input  wire signed [DATA_W-1:0]  left_entry,
	input  wire signed [DATA_W-1:0]  right_entry,
	output logic signed [DATA_W-1:0] entry,
	output logic                     match
);

	logic signed [DATA_W-1:0] entry_q;
	logic                     in_list;
	logic                     equal;

	// occupancy and compare
	assign in_list = CMP_W'(index) < CMP_W'(cmd.cnt);
	assign equal   = entry_q == cmd.value;
	assign match   = in_list && equal;
	assign entry   = entry_q;

	// entry update: insert opens a slot, delete closes one, replace rewrites
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (index == cmd.idx) begin
				entry_q <= cmd.value;
			end else if (index > cmd.idx) begin
				entry_q <= left_entry;
			end
		end else if (cmd.del) begin
			if (index >= cmd.idx) begin
				entry_q <= right_entry;
			end
		end else if (cmd.rep && match) begin
			entry_q <= cmd.new_value;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/olist_chain.sv =====
// row of list cells, each linked to its left and right neighbor
// depends on olist_pkg and olist_cell
`default_nettype none

module olist_chain import olist_pkg::*; (
	input  wire             clk,
	input  cell_cmd_t       cmd,
	output logic [DEPTH-1:0] match
);

	logic signed [DATA_W-1:0] entry [DEPTH];

	// cell row; the first cell's left neighbor is never selected, the last cell keeps its own entry
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_w;
		logic signed [DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = cmd.value;
		end else begin : g_mid_l
			assign left_w = entry[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = entry[i];
		end else begin : g_mid_r
			assign right_w = entry[i+1];
		end

		olist_cell u_cell (
			.clk         (clk),
			.index       (IDX_W'(i)),
			.cmd         (cmd),
			.left_entry  (left_w),
			.right_entry (right_w),
			.entry       (entry[i]),
			.match       (match[i])
		);
	end

endmodule

`default_nettype wire

// ===== rtl/ordered_list_engine.sv =====
// append, insert, delete and replace: result in the cycle after the item is taken,
//   one item per cycle while the result is taken as it appears
// search: result once the scan of the registered match vector ends, one 8-bit group
//   per cycle, stopping at the first group with a match or after the last group
// reset: list length cleared to zero, entries undefined until written
`default_nettype none

module ordered_list_engine import olist_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	olist_req_if.sink   req,
	olist_rsp_if.source rsp
);

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              rsp_valid_q;
	status_t           status_q;
	logic [CNT_W-1:0]  found_q;
	logic [CNT_W-1:0]  len_q;
	logic [PAD_W-1:0]  match_q;
	logic [GRP_W-1:0]  grp_q;

	logic              accept;
	logic              full;
	logic [CMP_W-1:0]  pos_w;
	logic [CMP_W-1:0]  cnt_w;
	logic [CMP_W-1:0]  idx_w;
	logic              ins_d;
	logic              del_d;
	logic              rep_d;
	logic              search_d;
	status_t           status_d;
	logic [CNT_W-1:0]  cnt_next;
	cell_cmd_t         cmd;
	logic [DEPTH-1:0]  match;
	logic [SCAN_W-1:0] grp_bits;
	logic              grp_hit;
	logic [SCAN_LG-1:0] hit_idx;
	logic              last_grp;
	logic [CNT_W-1:0]  hit_pos;

	// handshake: one item in flight, response slot must be free or draining
	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);

	assign full  = cnt_q == CNT_W'(DEPTH);
	assign pos_w = CMP_W'(req.position);
	assign cnt_w = CMP_W'(cnt_q);

	// request decode and range checks
	always_comb begin
		ins_d    = 1'b0;
		del_d    = 1'b0;
		rep_d    = 1'b0;
		search_d = 1'b0;
		status_d = ST_DONE;
		idx_w    = pos_w - CMP_W'(1);
		cnt_next = cnt_q;
		unique case (req.opcode)
			OP_APPEND: begin
				idx_w = cnt_w;
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ins_d    = 1'b1;
					cnt_next = cnt_q + CNT_W'(1);
				end
			end
			OP_INSERT: begin
				if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
					status_d = ST_RANGE;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					ins_d    = 1'b1;
					cnt_next = cnt_q + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				if (pos_w == '0 || pos_w > cnt_w) begin
					status_d = ST_RANGE;
				end else begin
					del_d    = 1'b1;
					cnt_next = cnt_q - CNT_W'(1);
				end
			end
			OP_SEARCH: begin
				search_d = 1'b1;
			end
			OP_REPLACE: begin
				rep_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// command to the cell row, active only on the accepting edge
	always_comb begin
		cmd.ins       = accept && ins_d;
		cmd.del       = accept && del_d;
		cmd.rep       = accept && rep_d;
		cmd.idx       = idx_w[IDX_W-1:0];
		cmd.cnt       = cnt_q;
		cmd.value     = req.value;
		cmd.new_value = req.new_value;
	end

	olist_chain u_chain (
		.clk   (clk),
		.cmd   (cmd),
		.match (match)
	);

	// first match inside the current group of the scan
	assign grp_bits = match_q[grp_q*SCAN_W +: SCAN_W];
	assign grp_hit  = |grp_bits;
	assign last_grp = grp_q == GRP_W'(NGRP - 1);

	always_comb begin
		hit_idx = '0;
		for (int j = SCAN_W - 1; j >= 0; j--) begin
			if (grp_bits[j]) begin
				hit_idx = SCAN_LG'(j);
			end
		end
	end

	assign hit_pos = CNT_W'({grp_q, hit_idx}) + CNT_W'(1);

	// control, length, scan and response registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= ST_DONE;
			found_q     <= '0;
			len_q       <= '0;
			match_q     <= '0;
			grp_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (search_d) begin
							state_q <= S_SCAN;
							match_q <= PAD_W'(match);
							grp_q   <= '0;
						end else begin
							rsp_valid_q <= 1'b1;
							status_q    <= status_d;
							found_q     <= '0;
							cnt_q       <= cnt_next;
							len_q       <= cnt_next;
						end
					end
				end
				S_SCAN: begin
					if (grp_hit || last_grp) begin
						state_q     <= S_IDLE;
						rsp_valid_q <= 1'b1;
						status_q    <= ST_DONE;
						found_q     <= grp_hit ? hit_pos : '0;
						len_q       <= cnt_q;
					end else begin
						grp_q <= grp_q + GRP_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// response port
	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = status_q;
	assign rsp.found_position = LEN_W'(found_q);
	assign rsp.list_length    = LEN_W'(len_q);

endmodule

`default_nettype wire

// ===== rtl/olist_checker.sv =====
// port-level assertions for the ordered list engine, bound to the top level
// depends on olist_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module olist_checker import olist_pkg::*; (
	input wire             clk,
	input wire             arst_n,
	input wire             in_valid,
	input wire             in_ready,
	input wire             out_valid,
	input wire             out_ready,
	input wire [1:0]       status,
	input wire [LEN_W-1:0] found_position,
	input wire [LEN_W-1:0] list_length
);

	// a stalled response keeps its fields
	`OLIST_ASSERT_NXT(a_rsp_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(found_position) && $stable(list_length), "response changed while stalled")

	// no new item while an untaken response blocks the output
	`OLIST_ASSERT_IMP(a_no_accept_blocked, clk, arst_n, in_valid && in_ready, !out_valid || out_ready, "item taken while response is blocked")

	// a full store is reported only at full length
	`OLIST_ASSERT_IMP(a_full_len, clk, arst_n, out_valid && status == ST_FULL, list_length == LEN_W'(DEPTH), "store full reported below capacity")

	// a found position comes only with a successful status
	`OLIST_ASSERT_IMP(a_found_done, clk, arst_n, out_valid && found_position != '0, status == ST_DONE, "found position with error status")

endmodule

bind ordered_list_engine olist_checker u_olist_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (req.valid),
	.in_ready       (req.ready),
	.out_valid      (rsp.valid),
	.out_ready      (rsp.ready),
	.status         (rsp.status),
	.found_position (rsp.found_position),
	.list_length    (rsp.list_length)
);

`default_nettype wire
